// ===== hdl/rop_pkg.sv =====
// Package: shared constants, command codes and types for the rectangle overpaint block.
package rop_pkg;

    localparam int MAX_RECTS  = 4096;
    localparam int IDX_BITS   = $clog2(MAX_RECTS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int COORD_BITS = 16;
    localparam int COLOR_BITS = 12;
    localparam int BOX_BITS   = 4 * COORD_BITS;
    localparam int ENTRY_BITS = BOX_BITS + COLOR_BITS;
    localparam int MEM_DEPTH  = 2 * MAX_RECTS;
    localparam int ADDR_BITS  = IDX_BITS + 1;
    localparam int AREA_BITS  = 32;

    localparam logic [1:0] CMD_PAINT = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [COORD_BITS-1:0] CANVAS_RESET = 16'd1024;

    typedef struct packed {
        logic [COORD_BITS-1:0] yh;
        logic [COORD_BITS-1:0] xh;
        logic [COORD_BITS-1:0] yl;
        logic [COORD_BITS-1:0] xl;
    } t_box;

    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        t_box                  box;
    } t_entry;

    typedef struct packed {
        logic [1:0]            command;
        t_box                  box;
        logic [COLOR_BITS-1:0] paint_color;
    } t_item;

    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic                 status;
    } t_result;

endpackage

// ===== hdl/rop_if.sv =====
// Interfaces: valid/ready item, result and configuration channels.
interface rop_item_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic [rop_pkg::COORD_BITS-1:0]    x_low;
    logic [rop_pkg::COORD_BITS-1:0]    y_low;
    logic [rop_pkg::COORD_BITS-1:0]    x_high;
    logic [rop_pkg::COORD_BITS-1:0]    y_high;
    logic [rop_pkg::COLOR_BITS-1:0]    paint_color;
    modport source (output valid, command, x_low, y_low, x_high, y_high, paint_color,
                    input ready);
    modport sink   (input valid, command, x_low, y_low, x_high, y_high, paint_color,
                    output ready);
endinterface

interface rop_result_if;
    logic                             valid;
    logic                             ready;
    logic [rop_pkg::AREA_BITS-1:0]    area;
    logic                             status;
    modport source (output valid, area, status, input ready);
    modport sink   (input valid, area, status, output ready);
endinterface

interface rop_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rop_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/rop_split.sv =====
// Piece generator: one of the up to four uncovered pieces of a stored box per step.
module rop_split (
    input  rop_pkg::t_box  i_stored,
    input  rop_pkg::t_box  i_paint,
    input  logic [1:0]     i_side,
    output logic           o_overlap,
    output logic           o_emit,
    output rop_pkg::t_box  o_piece
);
    rop_pkg::t_box r, a;
    logic [rop_pkg::COORD_BITS-1:0] mxl, mxh;

    always_comb begin
        r = i_stored;
        a = i_paint;
        o_overlap = !(r.xl >= a.xh || r.xh <= a.xl || r.yl >= a.yh || r.yh <= a.yl);
        mxl = (r.xl > a.xl) ? r.xl : a.xl;
        mxh = (r.xh < a.xh) ? r.xh : a.xh;
        o_piece = r;
        o_emit  = 1'b0;
        case (i_side)
            2'd0: begin
                o_emit  = r.xl < a.xl;
                o_piece = '{yh: r.yh, xh: a.xl, yl: r.yl, xl: r.xl};
            end
            2'd1: begin
                o_emit  = r.xh > a.xh;
                o_piece = '{yh: r.yh, xh: r.xh, yl: r.yl, xl: a.xh};
            end
            2'd2: begin
                o_emit  = r.yl < a.yl;
                o_piece = '{yh: a.yl, xh: mxh, yl: r.yl, xl: mxl};
            end
            default: begin
                o_emit  = r.yh > a.yh;
                o_piece = '{yh: r.yh, xh: mxh, yl: a.yh, xl: mxl};
            end
        endcase
    end
endmodule

// ===== hdl/rectangle_overpaint_area.sv =====
// Top level of the rectangle overpaint area block: sequencer, store and shared unit.
//
// Channels: i_item carries one command word (paint, query, clear); o_result returns
// exactly one word per item (area, status); i_cfg writes canvas width (index 0) and
// height (index 1), taken at any time and used by the next clear.
// A paint walks the active bank one stored box at a time (read, wait, split); the
// shared split unit looks at one side of an overlapped box per cycle and writes the
// survivors into the spare bank. A query walks the active bank (read, wait, sum)
// through one 16x16 multiplier and a saturating adder.
// The walk over the single store read port sets the time an item takes; one item at a time.
// Reset empties the list and selects bank 0; canvas registers return to 1024.
// The store itself is not cleared. A result waits in the output register until
// taken; the next item is accepted in the same cycle the result is taken.
module rectangle_overpaint_area (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rop_item_if.sink   i_item,
    rop_cfg_if.sink    i_cfg,
    rop_result_if.source o_result
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_SPLIT = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_TAIL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    rop_pkg::t_item r_item;
    logic [rop_pkg::COORD_BITS-1:0] r_width, r_height;
    logic r_bank;
    logic [rop_pkg::CNT_BITS-1:0] r_count, r_idx, r_n;
    logic [1:0] r_side;
    logic r_full;
    logic [rop_pkg::AREA_BITS:0] r_sum;
    logic [rop_pkg::AREA_BITS-1:0] r_prod;
    logic r_prod_ok;
    logic r_out_valid;
    rop_pkg::t_result r_out;

    logic we;
    logic [rop_pkg::ADDR_BITS-1:0] waddr, raddr;
    rop_pkg::t_entry wdata, rdata;

    logic overlap, pc_emit;
    rop_pkg::t_box piece;

    rop_ram #(.WIDTH(rop_pkg::ENTRY_BITS), .DEPTH(rop_pkg::MEM_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rop_split u_split (
        .i_stored  (rdata.box),
        .i_paint   (r_item.box),
        .i_side    (r_side),
        .o_overlap (overlap),
        .o_emit    (pc_emit),
        .o_piece   (piece)
    );

    logic accept, paint_empty;
    assign i_item.ready = (r_state == S_IDLE) && (!r_out_valid || o_result.ready);
    assign accept       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;
    assign o_result.valid  = r_out_valid;
    assign o_result.area   = r_out.area;
    assign o_result.status = r_out.status;
    assign paint_empty = (r_item.box.xl >= r_item.box.xh) || (r_item.box.yl >= r_item.box.yh);
    // Hold the address on the current entry until its walk step is over.
    assign raddr = {r_bank, r_idx[rop_pkg::IDX_BITS-1:0]};

    logic [rop_pkg::COORD_BITS-1:0] dw, dh;
    assign dw = (rdata.box.xh > rdata.box.xl) ? rdata.box.xh - rdata.box.xl : '0;
    assign dh = (rdata.box.yh > rdata.box.yl) ? rdata.box.yh - rdata.box.yl : '0;

    // Store write port: one piece, a survivor, the painted box, or the clear box.
    logic room;
    assign room = r_n < rop_pkg::CNT_BITS'(rop_pkg::MAX_RECTS);
    always_comb begin
        we    = 1'b0;
        waddr = {!r_bank, r_n[rop_pkg::IDX_BITS-1:0]};
        wdata = '{color: rdata.color, box: piece};
        if (r_state == S_SPLIT) begin
            if (!overlap) begin
                we    = room;
                wdata = rdata;
            end else begin
                we = room && pc_emit;
            end
        end else if (r_state == S_TAIL) begin
            we    = room;
            wdata = '{color: r_item.paint_color, box: r_item.box};
        end else if (r_state == S_IDLE && accept && i_item.command == rop_pkg::CMD_CLEAR) begin
            we    = (r_width != '0) && (r_height != '0);
            waddr = {r_bank, {rop_pkg::IDX_BITS{1'b0}}};
            wdata = '{color: rop_pkg::COLOR_BITS'(1),
                      box: '{yh: r_height, xh: r_width, yl: '0, xl: '0}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.command) inside
                        rop_pkg::CMD_PAINT, rop_pkg::CMD_QUERY: n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                if (r_item.command == rop_pkg::CMD_PAINT && paint_empty) n_state = S_DONE;
                else if (r_idx == r_count)
                    n_state = (r_item.command == rop_pkg::CMD_PAINT) ? S_TAIL : S_SUM;
                else n_state = S_WAIT;
            end
            S_WAIT: n_state = (r_item.command == rop_pkg::CMD_PAINT) ? S_SPLIT : S_SUM;
            S_SPLIT: if (!overlap || r_side == 2'd3) n_state = S_READ;
            S_SUM: n_state = (r_idx == r_count && !r_prod_ok) ? S_DONE :
                             (r_idx == r_count) ? S_SUM : S_READ;
            S_TAIL: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_width     <= rop_pkg::CANVAS_RESET;
            r_height    <= rop_pkg::CANVAS_RESET;
            r_prod_ok   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    rop_pkg::REG_WIDTH:  r_width  <= i_cfg.data;
                    rop_pkg::REG_HEIGHT: r_height <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE) r_out_valid <= 1'b1;
            else if (o_result.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item <= '{command: i_item.command,
                                    box: '{yh: i_item.y_high, xh: i_item.x_high,
                                           yl: i_item.y_low, xl: i_item.x_low},
                                    paint_color: i_item.paint_color};
                        r_idx  <= '0;
                        r_n    <= '0;
                        r_side <= 2'd0;
                        r_full <= 1'b0;
                        r_sum  <= '0;
                        r_prod_ok <= 1'b0;
                        if (i_item.command == rop_pkg::CMD_CLEAR)
                            r_count <= ((r_width != '0) && (r_height != '0))
                                       ? rop_pkg::CNT_BITS'(1) : '0;
                    end
                end
                S_READ: begin
                    r_side <= 2'd0;
                end
                S_SPLIT: begin
                    // Count every piece, written or not, to detect overflow.
                    if (!overlap || pc_emit) begin
                        if (!room) r_full <= 1'b1;
                        r_n <= r_n + 1'b1;
                    end
                    r_side <= r_side + 1'b1;
                    if (!overlap || r_side == 2'd3) r_idx <= r_idx + 1'b1;
                end
                S_WAIT: begin
                    // Multiply for the entry just read, if its colour matches, goes through r_prod to S_SUM.
                    r_prod_ok <= 1'b0;
                    if (r_item.command == rop_pkg::CMD_QUERY) begin
                        r_idx <= r_idx + 1'b1;
                        if (rdata.color == r_item.paint_color) begin
                            r_prod    <= rop_pkg::AREA_BITS'(dw) * rop_pkg::AREA_BITS'(dh);
                            r_prod_ok <= 1'b1;
                        end
                    end
                end
                S_SUM: begin
                    r_prod_ok <= 1'b0;
                    if (r_prod_ok) begin
                        r_sum <= ((r_sum + {1'b0, r_prod}) > {1'b0, {rop_pkg::AREA_BITS{1'b1}}})
                               ? {1'b0, {rop_pkg::AREA_BITS{1'b1}}} : r_sum + {1'b0, r_prod};
                    end
                end
                S_TAIL: begin
                    if (!r_full && room) begin
                        r_bank  <= !r_bank;
                        r_count <= r_n + 1'b1;
                        r_full  <= 1'b0;
                    end else begin
                        r_full <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_out.area  <= (r_item.command == rop_pkg::CMD_QUERY)
                                   ? r_sum[rop_pkg::AREA_BITS-1:0] : '0;
                    r_out.status <= (r_item.command == rop_pkg::CMD_PAINT) && r_full;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/rop_checker.sv =====
// Checker: port-level properties of the rectangle overpaint block, bound to the top level.
module rop_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [1:0] in_command,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] out_area,
    input logic out_status
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_area) && $stable(out_status))
        else $error("result dropped while stalled");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");
    a_clear_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_command == 2'd2 |-> ##2 out_valid && !out_status
        && out_area == 32'd0)
        else $error("clear result wrong");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind rectangle_overpaint_area rop_checker u_rop_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_item.valid),
    .in_ready   (i_item.ready),
    .in_command (i_item.command),
    .out_valid  (o_result.valid),
    .out_ready  (o_result.ready),
    .out_area   (o_result.area),
    .out_status (o_result.status)
);
